>>> sv/wss_pkg.sv
// Shared constants, codes and controller/datapath interface types for weighted_spatial_spread.
package wss_pkg;

  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int WEIGHT_W   = 16;
  localparam int SPREAD_W   = 32;
  localparam int CDIST_W    = 16;
  localparam int MAX_DIM_DEF = 4096;

  localparam int SUM_W_W    = 40;
  localparam int SUM_X_W    = 52;
  localparam int SUM_XX_W   = 64;
  localparam int SUM_D_W    = 56;

  // Per-pixel offset divider and final wide arithmetic.
  localparam int OFS_W      = 16;
  localparam int PDIV_W     = CFG_W + 1 + 15;
  localparam int ROOT_W     = 16;
  localparam int SQ_W       = 32;
  localparam int WIDE_W     = 128;
  localparam int MPLIER_W   = 64;
  localparam int CNT_W      = 6;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } reg_idx_e;

  // Products formed one after another for the variance numerator and denominator.
  typedef enum logic [2:0] {
    PROD_S_XX = 3'd0,
    PROD_S_YY = 3'd1,
    PROD_X_X  = 3'd2,
    PROD_Y_Y  = 3'd3,
    PROD_S_S  = 3'd4
  } prod_e;

  typedef struct packed {
    logic        accept;
    logic        pdiv_step;
    logic        psq;
    logic        sqrt_step;
    logic [3:0]  sqrt_bit;
    logic        pacc;
    logic        mul_step;
    prod_e       step_prod;
    logic        mul_load;
    prod_e       load_prod;
    logic        fin_shift;
    logic        sat_chk;
    logic        qdiv_step;
    logic        cinit;
    logic        out_load;
  } cmd_t;

  typedef struct packed {
    logic last_px;
    logic sum_zero;
    logic out_valid;
  } status_t;

endpackage

>>> sv/wss_ctrl.sv
// Sequencing state machine for weighted_spatial_spread.
module wss_ctrl import wss_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_stall_i,
  input  status_t st_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_PDIV  = 13'b0000000000010,
    S_PSQ   = 13'b0000000000100,
    S_PSQRT = 13'b0000000001000,
    S_PACC  = 13'b0000000010000,
    S_FCHK  = 13'b0000000100000,
    S_MUL   = 13'b0000001000000,
    S_SHIFT = 13'b0000010000000,
    S_SAT   = 13'b0000100000000,
    S_QDIV  = 13'b0001000000000,
    S_CINIT = 13'b0010000000000,
    S_CDIV  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  prod_e             prod_q, prod_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    prod_d     = prod_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = CNT_W'(15);
          state_d      = S_PDIV;
        end
      end
      S_PDIV: begin
        cmd_o.pdiv_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_PSQ;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_PSQ: begin
        cmd_o.psq = 1'b1;
        cnt_d     = CNT_W'(15);
        state_d   = S_PSQRT;
      end
      S_PSQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cmd_o.sqrt_bit  = cnt_q[3:0];
        if (cnt_q == '0) begin
          state_d = S_PACC;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_PACC: begin
        cmd_o.pacc = 1'b1;
        state_d    = st_i.last_px ? S_FCHK : S_IDLE;
      end
      S_FCHK: begin
        if (st_i.sum_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.mul_load  = 1'b1;
          cmd_o.load_prod = PROD_S_XX;
          prod_d          = PROD_S_XX;
          cnt_d           = CNT_W'(63);
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step  = 1'b1;
        cmd_o.step_prod = prod_q;
        if (cnt_q == '0) begin
          if (prod_q == PROD_S_S) begin
            state_d = S_SHIFT;
          end else begin
            prod_d          = prod_e'(prod_q + 3'd1);
            cmd_o.mul_load  = 1'b1;
            cmd_o.load_prod = prod_e'(prod_q + 3'd1);
            cnt_d           = CNT_W'(63);
          end
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.fin_shift = 1'b1;
        state_d         = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat_chk = 1'b1;
        cnt_d         = CNT_W'(31);
        state_d       = S_QDIV;
      end
      S_QDIV: begin
        cmd_o.qdiv_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_CINIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_CINIT: begin
        cmd_o.cinit = 1'b1;
        cnt_d       = CNT_W'(15);
        state_d     = S_CDIV;
      end
      S_CDIV: begin
        cmd_o.qdiv_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_OUT: begin
        if (!st_i.out_valid || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      prod_q  <= PROD_S_XX;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      prod_q  <= prod_d;
    end
  end

  // A result is never written over one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !(st_i.out_valid && out_stall_i))
    else $error("result register overwritten while stalled");

  // A frame end with weight goes through the product sweep.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FCHK && !st_i.sum_zero) |=> (state_q == S_MUL && cnt_q == CNT_W'(63)))
    else $error("product sweep not started at frame end");

  // Items are only taken while the sequencer is idle.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input open while busy");

endmodule

>>> sv/wss_dp.sv
// Datapath of weighted_spatial_spread: counters, moment sums, dividers and result register.
module wss_dp import wss_pkg::*; #(
  parameter int MaxDim = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic [WEIGHT_W-1:0]   weight_i,
  input  logic                  out_take_i,
  input  cmd_t                  cmd_i,
  output status_t               st_o,
  output logic                  out_valid_o,
  output logic [SPREAD_W-1:0]   spread_o,
  output logic [CDIST_W-1:0]    center_dist_o,
  output logic                  empty_map_o
);

  localparam int CW = $clog2(MaxDim);

  function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > CFG_W'(MaxDim)) r = CFG_W'(MaxDim);
    return r;
  endfunction

  // Configuration and frame position.
  logic [CFG_W-1:0] wd_q, ht_q, wd_eff, ht_eff;
  logic [CW-1:0]    col_q, col_d, row_q, row_d;
  logic [CFG_W-1:0] col_ext, row_ext;
  logic             row_end, last_px;

  // Pixel registers.
  logic [WEIGHT_W-1:0] w_q;
  logic [CW-1:0]       x_q, y_q;
  logic [2*CW-1:0]     xx_q, yy_q, xx_d, yy_d;
  logic                last_q;
  logic [CFG_W:0]      twice_x, twice_y, ax, ay;
  logic [PDIV_W-1:0]   xr_q, xs_q, yr_q, ys_q;
  logic [OFS_W-1:0]    dx_q, dy_q;
  logic [SQ_W-1:0]     v_q, tt;
  logic [ROOT_W-1:0]   root_q, t;
  logic                xge, yge;

  // Moment sums.
  logic [SUM_W_W-1:0]  sw_q;
  logic [SUM_X_W-1:0]  sx_q, sy_q;
  logic [SUM_XX_W-1:0] sxx_q, syy_q;
  logic [SUM_D_W-1:0]  sd_q;
  logic [WEIGHT_W+CW-1:0]   wx, wy;
  logic [WEIGHT_W+2*CW-1:0] wxx, wyy;
  logic [WEIGHT_W+ROOT_W-1:0] wd;

  // Frame-end arithmetic.
  logic [WIDE_W-1:0]   acc_q, den_q, mcand_q, rem_q, dsh_q;
  logic [MPLIER_W-1:0] mplier_q, ld_a, ld_b;
  logic [SPREAD_W-1:0] quo_q, spread_res_q;
  logic                sat_q, rge;

  logic                out_valid_q, clear;
  logic                empty;

  assign wd_eff  = eff_dim(wd_q);
  assign ht_eff  = eff_dim(ht_q);
  assign col_ext = CFG_W'(col_q);
  assign row_ext = CFG_W'(row_q);
  assign row_end = (col_ext + CFG_W'(1)) >= wd_eff;
  assign last_px = row_end && ((row_ext + CFG_W'(1)) >= ht_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_px) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  assign xx_d = {{CW{1'b0}}, col_q} * {{CW{1'b0}}, col_q};
  assign yy_d = {{CW{1'b0}}, row_q} * {{CW{1'b0}}, row_q};

  // Offset from the centre in half-pixels: |2p - n|.
  assign twice_x = {col_ext, 1'b0};
  assign twice_y = {row_ext, 1'b0};
  assign ax = (twice_x >= {1'b0, wd_eff}) ? twice_x - {1'b0, wd_eff} : {1'b0, wd_eff} - twice_x;
  assign ay = (twice_y >= {1'b0, ht_eff}) ? twice_y - {1'b0, ht_eff} : {1'b0, ht_eff} - twice_y;

  assign xge = xr_q >= xs_q;
  assign yge = yr_q >= ys_q;

  assign t  = root_q | (ROOT_W'(1) << cmd_i.sqrt_bit);
  assign tt = t * t;

  assign wx  = {{CW{1'b0}}, w_q} * {{WEIGHT_W{1'b0}}, x_q};
  assign wy  = {{CW{1'b0}}, w_q} * {{WEIGHT_W{1'b0}}, y_q};
  assign wxx = {{2*CW{1'b0}}, w_q} * {{WEIGHT_W{1'b0}}, xx_q};
  assign wyy = {{2*CW{1'b0}}, w_q} * {{WEIGHT_W{1'b0}}, yy_q};
  assign wd  = {{ROOT_W{1'b0}}, w_q} * {{WEIGHT_W{1'b0}}, root_q};

  always_comb begin
    ld_a = MPLIER_W'(sw_q);
    ld_b = sxx_q;
    unique case (cmd_i.load_prod)
      PROD_S_XX: begin ld_a = MPLIER_W'(sw_q); ld_b = sxx_q; end
      PROD_S_YY: begin ld_a = MPLIER_W'(sw_q); ld_b = syy_q; end
      PROD_X_X:  begin ld_a = MPLIER_W'(sx_q); ld_b = MPLIER_W'(sx_q); end
      PROD_Y_Y:  begin ld_a = MPLIER_W'(sy_q); ld_b = MPLIER_W'(sy_q); end
      PROD_S_S:  begin ld_a = MPLIER_W'(sw_q); ld_b = MPLIER_W'(sw_q); end
      default:   begin ld_a = '0; ld_b = '0; end
    endcase
  end

  assign rge   = rem_q >= dsh_q;
  assign empty = (sw_q == '0);
  assign clear = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT);

  // Control state and the sums, which restart at reset and at every frame start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wd_q        <= WIDTH_RST;
      ht_q        <= HEIGHT_RST;
      col_q       <= '0;
      row_q       <= '0;
      sw_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxx_q       <= '0;
      syy_q       <= '0;
      sd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (cmd_i.pacc) begin
        sw_q  <= sw_q + SUM_W_W'(w_q);
        sx_q  <= sx_q + SUM_X_W'(wx);
        sy_q  <= sy_q + SUM_X_W'(wy);
        sxx_q <= sxx_q + SUM_XX_W'(wxx);
        syy_q <= syy_q + SUM_XX_W'(wyy);
        sd_q  <= sd_q + SUM_D_W'(wd);
      end
      // The result register fills at a frame end and empties when its item is taken.
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        sw_q  <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sd_q  <= '0;
      end else if (out_take_i) begin
        out_valid_q <= 1'b0;
      end
      if (clear) begin
        col_q <= '0;
        row_q <= '0;
        sw_q  <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sd_q  <= '0;
        if (cfg_idx_i == REG_WIDTH) wd_q <= cfg_data_i;
        else ht_q <= cfg_data_i;
      end
    end
  end

  // Working registers of one pixel and of the frame end.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      w_q    <= weight_i;
      x_q    <= col_q;
      y_q    <= row_q;
      xx_q   <= xx_d;
      yy_q   <= yy_d;
      last_q <= last_px;
      xr_q   <= {ax, 15'b0};
      yr_q   <= {ay, 15'b0};
      xs_q   <= PDIV_W'({wd_eff, 15'b0});
      ys_q   <= PDIV_W'({ht_eff, 15'b0});
    end
    if (cmd_i.pdiv_step) begin
      if (xge) xr_q <= xr_q - xs_q;
      if (yge) yr_q <= yr_q - ys_q;
      dx_q <= {dx_q[OFS_W-2:0], xge};
      dy_q <= {dy_q[OFS_W-2:0], yge};
      xs_q <= xs_q >> 1;
      ys_q <= ys_q >> 1;
    end
    if (cmd_i.psq) begin
      v_q    <= (SQ_W'(dx_q) * SQ_W'(dx_q)) + (SQ_W'(dy_q) * SQ_W'(dy_q));
      root_q <= '0;
    end
    if (cmd_i.sqrt_step && (tt <= v_q)) begin
      root_q <= t;
    end
    if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        unique case (cmd_i.step_prod)
          PROD_S_XX, PROD_S_YY: acc_q <= acc_q + mcand_q;
          PROD_X_X, PROD_Y_Y:   acc_q <= acc_q - mcand_q;
          PROD_S_S:             den_q <= den_q + mcand_q;
          default:              acc_q <= acc_q;
        endcase
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
    if (cmd_i.mul_load) begin
      mcand_q  <= WIDE_W'(ld_a);
      mplier_q <= ld_b;
      if (cmd_i.load_prod == PROD_S_XX) begin
        acc_q <= '0;
        den_q <= '0;
      end
    end
    if (cmd_i.fin_shift) begin
      rem_q <= acc_q << 8;
      dsh_q <= den_q << 32;
    end
    if (cmd_i.sat_chk) begin
      sat_q <= rge;
      dsh_q <= dsh_q >> 1;
      quo_q <= '0;
    end
    if (cmd_i.qdiv_step) begin
      if (rge) rem_q <= rem_q - dsh_q;
      quo_q <= {quo_q[SPREAD_W-2:0], rge};
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.cinit) begin
      spread_res_q <= sat_q ? '1 : quo_q;
      rem_q        <= WIDE_W'(sd_q);
      dsh_q        <= WIDE_W'(sw_q) << 15;
      quo_q        <= '0;
    end
    if (cmd_i.out_load) begin
      spread_o      <= empty ? '0 : spread_res_q;
      center_dist_o <= empty ? '0 : quo_q[CDIST_W-1:0];
      empty_map_o   <= empty;
    end
  end

  assign out_valid_o = out_valid_q;

  assign st_o.last_px   = last_q;
  assign st_o.sum_zero  = empty;
  assign st_o.out_valid = out_valid_q;

  // The column counter never leaves the effective width.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_ext < wd_eff)
    else $error("column counter outside the row");

  // The root found for a pixel never squares above its radicand.
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pacc |-> ((SQ_W'(root_q) * SQ_W'(root_q)) <= v_q))
    else $error("square root too large");

  // Delivering a result starts a fresh frame.
  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (sw_q == '0 && sd_q == '0))
    else $error("sums not cleared after frame result");

endmodule

>>> sv/weighted_spatial_spread.sv
// Top level of weighted_spatial_spread: weighted spatial variance and centre distance of a map.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid_i, in_stall_o, weight_i          | item in
//  output  | out_valid_o, out_stall_i, spread_o,       | item out
//          | center_dist_o, empty_map_o                |
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i           | write only
//
// Each pixel item is accepted, then runs through the two offset dividers (one quotient bit a
// cycle each), a squaring step, a bit-by-bit square root and an addition into the sums. The
// last pixel of a frame then goes through the serial shift-add multiplier (five 64-bit
// products) and the shared restoring divider (32 quotient bits for the spread, then 16 for
// the centre distance). No new item is taken until the sequencer is idle again.
// Reset restores 640 by 480 and clears counters and sums; a write to the width or height register restarts the frame.
// A finished result waits in the output register under stall; the next frame is accepted
// meanwhile, and only a second frame end waits for the output register to drain.
module weighted_spatial_spread import wss_pkg::*; #(
  parameter int MaxDim = MAX_DIM_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WEIGHT_W-1:0]  weight_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SPREAD_W-1:0]  spread_o,
  output logic [CDIST_W-1:0]   center_dist_o,
  output logic                 empty_map_o
);

  cmd_t    cmd;
  status_t st;
  logic    out_take;

  // A waiting result item leaves at an edge where it is valid and not stalled.
  assign out_take = out_valid_o && !out_stall_i;

  // The controller walks each pixel and each frame end through the datapath's steps.
  wss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  // The datapath holds the frame position, the moment sums and the result register.
  wss_dp #(
    .MaxDim (MaxDim)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .weight_i      (weight_i),
    .out_take_i    (out_take),
    .cmd_i         (cmd),
    .st_o          (st),
    .out_valid_o   (out_valid_o),
    .spread_o      (spread_o),
    .center_dist_o (center_dist_o),
    .empty_map_o   (empty_map_o)
  );

endmodule
